### src/aat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aat_pkg
// Shared types and constants for the alias/address table.
// ----------------------------------------------------------------------------
package aat_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int KEY_W  = 40;
    localparam int ADDR_W = 32;
    localparam int OP_W   = 3;
    localparam int ST_W   = 3;
    localparam int LOC_W  = 16;

    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_LOCATE = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [ST_W-1:0] ST_DUP_ALIAS = 3'd2;
    localparam logic [ST_W-1:0] ST_DUP_ADDR  = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd4;
    localparam logic [ST_W-1:0] ST_NONE_LOC  = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [KEY_W-1:0]  key_hi;
        logic [KEY_W-1:0]  key_lo;
        logic [ADDR_W-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic [KEY_W-1:0]  key_hi;
        logic [KEY_W-1:0]  key_lo;
        logic [ADDR_W-1:0] addr;
        logic              valid;
        logic              flag;
    } t_entry;

    // broadcast to every cell
    typedef struct packed {
        logic shift_down;  // insert at head: take from previous cell
        logic rotate;      // take from next cell unconditionally
        logic remove;      // take from next cell at and after the hit
        logic write_addr;  // overwrite address of the hit cell
        logic capture;     // latch locate match into flag
    } t_cell_ctl;

endpackage

`default_nettype wire

### src/aat_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aat_cell
// One table slot: holds an entry, compares it with the current command and
// passes its contents to a neighbor on insert, delete or rotate.
// ----------------------------------------------------------------------------
module aat_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  aat_pkg::t_cell_ctl   i_ctl,
    input  aat_pkg::t_cmd        i_cmd,
    input  aat_pkg::t_entry      i_prev,
    input  aat_pkg::t_entry      i_next,
    input  wire                  i_hit_in,
    output aat_pkg::t_entry      o_ent,
    output logic                 o_key_match,
    output logic                 o_addr_match,
    output logic                 o_hit_out
);

    aat_pkg::t_entry r_ent;
    logic            w_loc_match;
    logic            w_take_next;

    assign o_key_match  = r_ent.valid && (r_ent.key_hi == i_cmd.key_hi)
                          && (r_ent.key_lo == i_cmd.key_lo);
    assign o_addr_match = r_ent.valid && (r_ent.addr == i_cmd.addr);
    assign w_loc_match  = r_ent.valid && (r_ent.addr[aat_pkg::ADDR_W-1 -: aat_pkg::LOC_W]
                          == i_cmd.addr[aat_pkg::ADDR_W-1 -: aat_pkg::LOC_W]);
    // hit at this cell or any newer one
    assign o_hit_out    = i_hit_in | o_key_match;
    assign w_take_next  = i_ctl.rotate | (i_ctl.remove & o_hit_out);
    assign o_ent        = r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
            r_ent.flag  <= 1'b0;
        end else begin
            if (i_ctl.shift_down) begin
                r_ent <= i_prev;
            end else if (w_take_next) begin
                r_ent <= i_next;
            end else begin
                if (i_ctl.write_addr && o_key_match) begin
                    r_ent.addr <= i_cmd.addr;
                end
                if (i_ctl.capture) begin
                    r_ent.flag <= w_loc_match;
                end
            end
        end
    end

endmodule

`default_nettype wire

### src/alias_address_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A command is registered when accepted in S_IDLE; its result is registered in S_EXEC
// once the output register is free. A new command is taken only back in S_IDLE. Locate
// rotates the cell chain once when any entry matches, else it reports ST_NONE_LOC.
// Output backpressure stalls the rotation while a matching entry is at the head.
// Reset (synchronous, active low) clears valid bits, entry count and handshake
// state; keys and addresses are not cleared.
// ----------------------------------------------------------------------------
// alias_address_table_top
// Newest-first alias to IPv4 table built as a chain of compare/shift cells.
// ----------------------------------------------------------------------------
module alias_address_table_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  wire  [111:0] i_s_axis_tdata,  // alias_hi[39:0], alias_lo[79:40], address[111:80]
    input  wire  [2:0]   i_s_axis_tuser,  // opcode[2:0]
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    output logic [111:0] o_m_axis_tdata,  // found_address[31:0], found_alias_hi[71:32],
                                          // found_alias_lo[111:72]
    output logic [2:0]   o_m_axis_tuser,  // status[2:0]
    output logic         o_m_axis_tlast
);

    localparam int D = aat_pkg::TABLE_DEPTH;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_LOC} t_state;

    t_state                        r_state, n_state;
    aat_pkg::t_cmd                 r_cmd, n_cmd;
    logic [aat_pkg::CNT_W-1:0]     r_count, n_count;
    logic [aat_pkg::IDX_W-1:0]     r_rot, n_rot;
    logic                          r_m_valid, n_m_valid;
    logic [aat_pkg::ST_W-1:0]      r_m_status, n_m_status;
    logic [aat_pkg::ADDR_W-1:0]    r_m_addr, n_m_addr;
    logic [aat_pkg::KEY_W-1:0]     r_m_hi, n_m_hi;
    logic [aat_pkg::KEY_W-1:0]     r_m_lo, n_m_lo;
    logic                          r_m_last, n_m_last;

    aat_pkg::t_cell_ctl            w_ctl;
    aat_pkg::t_entry               w_ent [D];
    aat_pkg::t_entry               w_prev [D];
    aat_pkg::t_entry               w_next [D];
    logic [D-1:0]                  w_key_m;
    logic [D-1:0]                  w_addr_m;
    logic [D-1:0]                  w_flags;
    logic [D:0]                    w_hit;
    logic [aat_pkg::ADDR_W-1:0]    w_sel_addr;
    logic                          w_out_free;
    logic                          w_head_flag;
    aat_pkg::t_entry               w_head_wrap;
    aat_pkg::t_entry               w_new_ent;

    assign w_hit[0] = 1'b0;

    always_comb begin
        w_new_ent        = '0;
        w_new_ent.key_hi = r_cmd.key_hi;
        w_new_ent.key_lo = r_cmd.key_lo;
        w_new_ent.addr   = r_cmd.addr;
        w_new_ent.valid  = 1'b1;
        w_head_wrap      = w_ent[0];
        w_head_wrap.flag = 1'b0;
    end

    genvar g;
    generate
        for (g = 0; g < D; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_prev[g] = w_new_ent;
            end else begin : g_mid
                assign w_prev[g] = w_ent[g-1];
            end
            if (g == D - 1) begin : g_last
                assign w_next[g] = w_ctl.rotate ? w_head_wrap : aat_pkg::t_entry'('0);
            end else begin : g_body
                assign w_next[g] = w_ent[g+1];
            end
            assign w_flags[g] = w_ent[g].flag;

            aat_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_cmd        (r_cmd),
                .i_prev       (w_prev[g]),
                .i_next       (w_next[g]),
                .i_hit_in     (w_hit[g]),
                .o_ent        (w_ent[g]),
                .o_key_match  (w_key_m[g]),
                .o_addr_match (w_addr_m[g]),
                .o_hit_out    (w_hit[g+1])
            );
        end
    endgenerate

    always_comb begin
        w_sel_addr = '0;
        for (int i = 0; i < D; i++) begin
            w_sel_addr = w_sel_addr | ({aat_pkg::ADDR_W{w_key_m[i]}} & w_ent[i].addr);
        end
    end

    assign w_out_free  = !r_m_valid || i_m_axis_tready;
    assign w_head_flag = w_ent[0].flag;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {r_m_lo, r_m_hi, r_m_addr};
    assign o_m_axis_tuser  = r_m_status;
    assign o_m_axis_tlast  = r_m_last;

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_count    = r_count;
        n_rot      = r_rot;
        n_m_valid  = r_m_valid && !i_m_axis_tready;
        n_m_status = r_m_status;
        n_m_addr   = r_m_addr;
        n_m_hi     = r_m_hi;
        n_m_lo     = r_m_lo;
        n_m_last   = r_m_last;
        w_ctl      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_cmd.opcode = i_s_axis_tuser;
                    n_cmd.key_hi = i_s_axis_tdata[39:0];
                    n_cmd.key_lo = i_s_axis_tdata[79:40];
                    n_cmd.addr   = i_s_axis_tdata[111:80];
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state    = S_IDLE;
                    n_m_valid  = 1'b1;
                    n_m_last   = 1'b1;
                    n_m_status = aat_pkg::ST_OK;
                    n_m_addr   = '0;
                    n_m_hi     = '0;
                    n_m_lo     = '0;
                    case (r_cmd.opcode)
                        aat_pkg::OP_ADD: begin
                            if (w_hit[D]) begin
                                n_m_status = aat_pkg::ST_DUP_ALIAS;
                            end else if (r_count == aat_pkg::CNT_W'(D)) begin
                                n_m_status = aat_pkg::ST_FULL;
                            end else begin
                                w_ctl.shift_down = 1'b1;
                                n_count  = r_count + 1'b1;
                                n_m_addr = r_cmd.addr;
                                n_m_hi   = r_cmd.key_hi;
                                n_m_lo   = r_cmd.key_lo;
                            end
                        end
                        aat_pkg::OP_LOOKUP: begin
                            if (w_hit[D]) begin
                                n_m_addr = w_sel_addr;
                                n_m_hi   = r_cmd.key_hi;
                                n_m_lo   = r_cmd.key_lo;
                            end else begin
                                n_m_status = aat_pkg::ST_NOT_FOUND;
                            end
                        end
                        aat_pkg::OP_UPDATE: begin
                            if (!w_hit[D]) begin
                                n_m_status = aat_pkg::ST_NOT_FOUND;
                            end else if (|w_addr_m) begin
                                n_m_status = aat_pkg::ST_DUP_ADDR;
                            end else begin
                                w_ctl.write_addr = 1'b1;
                                n_m_addr = r_cmd.addr;
                                n_m_hi   = r_cmd.key_hi;
                                n_m_lo   = r_cmd.key_lo;
                            end
                        end
                        aat_pkg::OP_DELETE: begin
                            if (w_hit[D]) begin
                                w_ctl.remove = 1'b1;
                                n_count  = r_count - 1'b1;
                                n_m_addr = w_sel_addr;
                                n_m_hi   = r_cmd.key_hi;
                                n_m_lo   = r_cmd.key_lo;
                            end else begin
                                n_m_status = aat_pkg::ST_NOT_FOUND;
                            end
                        end
                        aat_pkg::OP_LOCATE: begin
                            // flags latch now; results go out from S_LOC, or a not-found status if nothing matches
                            w_ctl.capture = 1'b1;
                            n_m_valid  = r_m_valid && !i_m_axis_tready;
                            n_m_status = r_m_status;
                            n_m_last   = r_m_last;
                            n_rot      = '0;
                            n_state    = S_LOC;
                        end
                        default: begin
                            n_m_valid  = r_m_valid && !i_m_axis_tready;
                            n_m_status = r_m_status;
                            n_m_last   = r_m_last;
                        end
                    endcase
                end
            end
            S_LOC: begin
                if (r_rot == '0 && !(|w_flags) && w_out_free) begin
                    n_m_valid  = 1'b1;
                    n_m_status = aat_pkg::ST_NONE_LOC;
                    n_m_addr   = '0;
                    n_m_hi     = '0;
                    n_m_lo     = '0;
                    n_m_last   = 1'b1;
                    n_state    = S_IDLE;
                end else if (r_rot == '0 && !(|w_flags)) begin
                    n_state = S_LOC;
                end else if (!w_head_flag || w_out_free) begin
                    w_ctl.rotate = 1'b1;
                    if (w_head_flag) begin
                        n_m_valid  = 1'b1;
                        n_m_status = aat_pkg::ST_OK;
                        n_m_addr   = w_ent[0].addr;
                        n_m_hi     = w_ent[0].key_hi;
                        n_m_lo     = w_ent[0].key_lo;
                        n_m_last   = !(|w_flags[D-1:1]);
                    end
                    n_rot = r_rot + 1'b1;
                    if (r_rot == aat_pkg::IDX_W'(D - 1)) begin
                        n_rot   = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rot     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_rot      <= n_rot;
            r_m_valid  <= n_m_valid;
            r_cmd      <= n_cmd;
            r_m_status <= n_m_status;
            r_m_addr   <= n_m_addr;
            r_m_hi     <= n_m_hi;
            r_m_lo     <= n_m_lo;
            r_m_last   <= n_m_last;
        end
    end

endmodule

`default_nettype wire
